// ===== rtl/tkm_pkg.sv =====
// ----------------------------------------------------------------------------
// tkm_pkg: shared types and constants of the timestamp merge counter
// Lane cell control and status, the scan token and counter addressing.
// ----------------------------------------------------------------------------
package tkm_pkg;

    localparam int MAX_LANES    = 8;
    localparam int MAX_CLUSTERS = 64;
    localparam int TIME_BITS    = 32;
    localparam int COUNT_BITS   = 32;

    localparam int LANE_W    = $clog2(MAX_LANES);
    localparam int LANE_CW   = LANE_W + 1;
    localparam int CL_W      = 6;
    localparam int CL_CW     = CL_W + 1;
    localparam int LIU_W     = 4;
    localparam int LIU_RESET = 8;
    localparam int CNT_DEPTH = MAX_LANES * MAX_CLUSTERS;
    localparam int CNT_AW    = $clog2(CNT_DEPTH);

    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_END  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] KIND_RECORD = 2'd0;
    localparam logic [1:0] KIND_COUNT  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    typedef struct packed {
        logic push;
        logic end_lane;
        logic pop;
    } lane_ctrl_t;

    typedef struct packed {
        logic head_valid;
        logic ended;
    } lane_stat_t;

    typedef struct packed {
        logic [LANE_W-1:0]    idx;
        logic                 found;
        logic                 blocked;
        logic [LANE_W-1:0]    best_lane;
        logic [TIME_BITS-1:0] best_time;
        logic [CL_W-1:0]      best_cluster;
    } scan_tok_t;

    function automatic logic [CNT_AW-1:0] cnt_addr(input logic [LANE_W-1:0] l,
                                                   input logic [CL_W-1:0] c);
        return CNT_AW'(int'(l) * MAX_CLUSTERS + int'(c));
    endfunction

endpackage

// ===== rtl/timestamp_kway_merge_counter_top.sv =====
// ----------------------------------------------------------------------------
// timestamp_kway_merge_counter_top: k-way timestamp merge with event counters
// Flow: a push or end that emits passes decode, the chain scan of MAX_LANES cells,
//   the pick, the counter read-modify-write and the output register, in that order.
// Throughput: one request at a time, set by the chain scan of one cell per cycle.
// Reset: a clearing pass over all CNT_DEPTH (512) counters zeroes them; no
//   request is taken until it ends. Configuration writes are taken throughout.
// ----------------------------------------------------------------------------
module timestamp_kway_merge_counter_top
    import tkm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [LIU_W-1:0]      cfg_write_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  logic [LANE_W-1:0]     lane,
    input  logic [TIME_BITS-1:0]  sample_time,
    input  logic [CL_W-1:0]       cluster,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            kind,
    output logic [LANE_W-1:0]     lane_out,
    output logic [CL_W-1:0]       cluster_out,
    output logic [TIME_BITS-1:0]  time_out,
    output logic [COUNT_BITS-1:0] count_out
);

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_EXEC  = 7'b0000100,
        S_SCAN  = 7'b0001000,
        S_PICK  = 7'b0010000,
        S_CNT   = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    state_t                state_reg, state_next;
    logic [LIU_W-1:0]      liu_reg;
    logic [LIU_W-1:0]      n_eff;

    logic [1:0]            cmd_reg;
    logic [LANE_W-1:0]     cmd_lane_reg;
    logic [TIME_BITS-1:0]  cmd_time_reg;
    logic [CL_W-1:0]       cmd_cl_reg;

    logic [LANE_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic [CNT_AW-1:0]     clr_addr_reg, clr_addr_next;

    logic [1:0]            res_kind_reg, res_kind_next;
    logic [LANE_W-1:0]     res_lane_reg, res_lane_next;
    logic [CL_W-1:0]       res_cl_reg, res_cl_next;
    logic [TIME_BITS-1:0]  res_time_reg, res_time_next;
    logic [COUNT_BITS-1:0] res_count_reg, res_count_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_load;
    logic [1:0]            out_kind_reg;
    logic [LANE_W-1:0]     out_lane_reg;
    logic [CL_W-1:0]       out_cl_reg;
    logic [TIME_BITS-1:0]  out_time_reg;
    logic [COUNT_BITS-1:0] out_count_reg;

    logic [COUNT_BITS-1:0] cnt_mem [CNT_DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [CNT_AW-1:0]     rd_addr;
    logic                  mem_we;
    logic [CNT_AW-1:0]     mem_wa;
    logic [COUNT_BITS-1:0] mem_wd;
    logic [COUNT_BITS-1:0] cnt_inc;

    lane_ctrl_t            ctrl_w   [MAX_LANES];
    lane_stat_t            stat_w   [MAX_LANES];
    scan_tok_t             tok_chain[MAX_LANES+1];
    scan_tok_t             tok_last;

    logic                  lane_ok;
    logic                  cl_ok;
    logic                  rd_lane_ok;
    logic                  push_err;
    logic                  end_err;

    // lanes in use, clamped to the legal range
    always_comb
    begin
        if (liu_reg == '0)
        begin
            n_eff = LIU_W'(1);
        end
        else if (liu_reg > LIU_W'(MAX_LANES))
        begin
            n_eff = LIU_W'(MAX_LANES);
        end
        else
        begin
            n_eff = liu_reg;
        end
    end

    assign tok_chain[0] = '0;

    for (genvar g = 0; g < MAX_LANES; g++)
    begin : g_cell
        tkm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl_w[g]),
            .wr_time    (cmd_time_reg),
            .wr_cluster (cmd_cl_reg),
            .n_eff      (n_eff),
            .tok_in     (tok_chain[g]),
            .tok_out    (tok_chain[g+1]),
            .stat       (stat_w[g])
        );
    end

    assign tok_last = tok_chain[MAX_LANES];

    assign lane_ok    = LIU_W'(cmd_lane_reg) < n_eff;
    assign cl_ok      = CL_CW'(cmd_cl_reg) < CL_CW'(MAX_CLUSTERS);
    assign rd_lane_ok = LANE_CW'(cmd_lane_reg) < LANE_CW'(MAX_LANES);
    assign push_err   = !lane_ok || !cl_ok || stat_w[cmd_lane_reg].head_valid
                        || stat_w[cmd_lane_reg].ended;
    assign end_err    = !lane_ok || stat_w[cmd_lane_reg].head_valid;

    assign cnt_inc = (rd_data_reg == '1) ? rd_data_reg : rd_data_reg + COUNT_BITS'(1);

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        clr_addr_next  = clr_addr_reg;
        res_kind_next  = res_kind_reg;
        res_lane_next  = res_lane_reg;
        res_cl_next    = res_cl_reg;
        res_time_next  = res_time_reg;
        res_count_next = res_count_reg;
        mem_we         = 1'b0;
        mem_wa         = clr_addr_reg;
        mem_wd         = '0;
        rd_addr        = cnt_addr(cmd_lane_reg, cmd_cl_reg);
        out_load       = 1'b0;
        for (int i = 0; i < MAX_LANES; i++)
        begin
            ctrl_w[i] = '0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we        = 1'b1;
                clr_addr_next = clr_addr_reg + CNT_AW'(1);
                if (clr_addr_reg == CNT_AW'(CNT_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_kind_next  = KIND_ERROR;
                res_lane_next  = cmd_lane_reg;
                res_cl_next    = cmd_cl_reg;
                res_time_next  = '0;
                res_count_next = '0;
                scan_cnt_next  = '0;
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (push_err)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            ctrl_w[cmd_lane_reg].push = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    CMD_END:
                    begin
                        if (end_err)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            ctrl_w[cmd_lane_reg].end_lane = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    CMD_READ:
                    begin
                        if (!rd_lane_ok || !cl_ok)
                        begin
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            // counter read issued this cycle, data lands in S_CNT
                            res_kind_next = KIND_COUNT;
                            state_next    = S_CNT;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + LANE_W'(1);
                if (scan_cnt_reg == LANE_W'(MAX_LANES - 1))
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                if (tok_last.found && !tok_last.blocked)
                begin
                    ctrl_w[tok_last.best_lane].pop = 1'b1;
                    rd_addr       = cnt_addr(tok_last.best_lane, tok_last.best_cluster);
                    res_kind_next = KIND_RECORD;
                    res_lane_next = tok_last.best_lane;
                    res_cl_next   = tok_last.best_cluster;
                    res_time_next = tok_last.best_time;
                    state_next    = S_CNT;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CNT:
            begin
                if (res_kind_reg == KIND_RECORD)
                begin
                    mem_we         = 1'b1;
                    mem_wa         = cnt_addr(res_lane_reg, res_cl_reg);
                    mem_wd         = cnt_inc;
                    res_count_next = cnt_inc;
                end
                else
                begin
                    res_count_next = rd_data_reg;
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            liu_reg       <= LIU_W'(LIU_RESET);
            scan_cnt_reg  <= '0;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write_en)
            begin
                liu_reg <= cfg_write_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg      <= cmd;
            cmd_lane_reg <= lane;
            cmd_time_reg <= sample_time;
            cmd_cl_reg   <= cluster;
        end
        res_kind_reg  <= res_kind_next;
        res_lane_reg  <= res_lane_next;
        res_cl_reg    <= res_cl_next;
        res_time_reg  <= res_time_next;
        res_count_reg <= res_count_next;
        if (out_load)
        begin
            out_kind_reg  <= res_kind_reg;
            out_lane_reg  <= res_lane_reg;
            out_cl_reg    <= res_cl_reg;
            out_time_reg  <= res_time_reg;
            out_count_reg <= res_count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            cnt_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= cnt_mem[rd_addr];
    end

    assign out_valid   = out_valid_reg;
    assign kind        = out_kind_reg;
    assign lane_out    = out_lane_reg;
    assign cluster_out = out_cl_reg;
    assign time_out    = out_time_reg;
    assign count_out   = out_count_reg;

endmodule

// ===== rtl/tkm_cell.sv =====
// ----------------------------------------------------------------------------
// tkm_cell: one lane of the merge chain
// Holds the lane's pending head and end flag, and folds its head into the
// scan token that moves one cell down the chain each cycle.
// ----------------------------------------------------------------------------
module tkm_cell
    import tkm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  lane_ctrl_t           ctrl,
    input  logic [TIME_BITS-1:0] wr_time,
    input  logic [CL_W-1:0]      wr_cluster,
    input  logic [LIU_W-1:0]     n_eff,
    input  scan_tok_t            tok_in,
    output scan_tok_t            tok_out,
    output lane_stat_t           stat
);

    logic                 hv_reg;
    logic                 hv_next;
    logic                 ended_reg;
    logic                 ended_next;
    logic [TIME_BITS-1:0] time_reg;
    logic [CL_W-1:0]      cl_reg;
    scan_tok_t            tok_reg;
    scan_tok_t            tok_next;
    logic                 active;

    always_comb
    begin
        hv_next    = hv_reg;
        ended_next = ended_reg;
        if (ctrl.push)
        begin
            hv_next = 1'b1;
        end
        if (ctrl.pop)
        begin
            hv_next = 1'b0;
        end
        if (ctrl.end_lane)
        begin
            ended_next = 1'b1;
        end
    end

    assign active = LIU_W'(tok_in.idx) < n_eff;

    always_comb
    begin
        tok_next     = tok_in;
        tok_next.idx = tok_in.idx + LANE_W'(1);
        if (active)
        begin
            // a live lane without a head stalls the merge
            if (!hv_reg && !ended_reg)
            begin
                tok_next.blocked = 1'b1;
            end
            if (hv_reg && (!tok_in.found || time_reg < tok_in.best_time))
            begin
                tok_next.found        = 1'b1;
                tok_next.best_lane    = tok_in.idx;
                tok_next.best_time    = time_reg;
                tok_next.best_cluster = cl_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg    <= 1'b0;
            ended_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            hv_reg    <= hv_next;
            ended_reg <= ended_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            time_reg <= wr_time;
            cl_reg   <= wr_cluster;
        end
    end

    assign tok_out         = tok_reg;
    assign stat.head_valid = hv_reg;
    assign stat.ended      = ended_reg;

endmodule

// ===== rtl/tkm_checker.sv =====
// ----------------------------------------------------------------------------
// tkm_checker: port-level checks of the timestamp merge counter
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
module tkm_checker
    import tkm_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [1:0]            kind,
    input logic [TIME_BITS-1:0]  time_out,
    input logic [COUNT_BITS-1:0] count_out
);

    // a stalled result stays up
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // one request in work at a time
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in work");

    // a merged record has bumped its counter at least once
    a_record_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_RECORD |-> count_out != '0)
        else $error("merged record with zero count");

    // replies and errors carry no time, errors no count
    a_reply_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_RECORD |->
            time_out == '0 && (kind != KIND_ERROR || count_out == '0))
        else $error("reply or error with stray time or count");

endmodule

bind timestamp_kway_merge_counter_top tkm_checker u_tkm_checker (.*);

// ===== tb/tb_timestamp_kway_merge_counter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_timestamp_kway_merge_counter_top: self-checking bench of the merge counter
// Drives push, end, read and spare requests through the valid/ready input,
// predicts each merged record, count reply and error in a behavioral copy of
// the lane heads and counters, and compares every result in order. A short
// table of directed requests comes first, then random phases that change the
// lanes-in-use register, the sender gaps and the receiver stalls.
// ----------------------------------------------------------------------------
module tb_timestamp_kway_merge_counter_top;
    import tkm_pkg::*;

    localparam logic [1:0] CMD_SPARE     = 2'd3;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         NUM_PHASES    = 7;
    localparam longint     TIMEOUT_NS    = 64'd6_000_000;

    typedef struct packed {
        logic [1:0]            kind;
        logic [LANE_W-1:0]     lane;
        logic [CL_W-1:0]       cluster;
        logic [TIME_BITS-1:0]  stamp;
        logic [COUNT_BITS-1:0] count;
    } merge_result_t;

    typedef struct packed {
        logic [1:0]           cmd;
        logic [LANE_W-1:0]    lane;
        logic [TIME_BITS-1:0] stamp;
        logic [CL_W-1:0]      cluster;
        logic                 typed;
        logic                 typed_has;
        merge_result_t        typed_res;
    } directed_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    logic [LIU_W-1:0]      cfg_write_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [1:0]            cmd;
    logic [LANE_W-1:0]     lane;
    logic [TIME_BITS-1:0]  sample_time;
    logic [CL_W-1:0]       cluster;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            kind;
    logic [LANE_W-1:0]     lane_out;
    logic [CL_W-1:0]       cluster_out;
    logic [TIME_BITS-1:0]  time_out;
    logic [COUNT_BITS-1:0] count_out;

    // predicted block state
    logic [LIU_W-1:0]      lanes_cfg;
    logic                  pend_valid   [MAX_LANES];
    logic                  closed       [MAX_LANES];
    logic [TIME_BITS-1:0]  pend_stamp   [MAX_LANES];
    logic [CL_W-1:0]       pend_cluster [MAX_LANES];
    logic [COUNT_BITS-1:0] tally        [MAX_LANES][MAX_CLUSTERS];

    merge_result_t expected_q[$];
    directed_row_t directed_rows[$];
    int            mismatch_count;
    int            idle_pct;
    int            stall_pct;

    int phase_lanes [NUM_PHASES] = '{3, 15, 0, 1, 5, 6, 8};
    int phase_idle  [NUM_PHASES] = '{0, 63, 0, 19, 0, 63, 19};
    int phase_stall [NUM_PHASES] = '{0, 0, 63, 19, 0, 0, 19};
    int phase_items [NUM_PHASES] = '{350, 300, 250, 250, 250, 250, 250};

    timestamp_kway_merge_counter_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .lane           (lane),
        .sample_time    (sample_time),
        .cluster        (cluster),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .lane_out       (lane_out),
        .cluster_out    (cluster_out),
        .time_out       (time_out),
        .count_out      (count_out)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int active_lane_count();
        if (lanes_cfg == '0)
            return 1;
        if (int'(lanes_cfg) > MAX_LANES)
            return MAX_LANES;
        return int'(lanes_cfg);
    endfunction

    function automatic merge_result_t error_reply(input logic [LANE_W-1:0] l,
                                                  input logic [CL_W-1:0] cl);
        merge_result_t r;
        r         = '0;
        r.kind    = KIND_ERROR;
        r.lane    = l;
        r.cluster = cl;
        return r;
    endfunction

    // One merge attempt: every open lane in use must hold a head.
    task automatic merge_attempt(output bit has, output merge_result_t res);
        int  n;
        int  i;
        int  best;
        bit  found;
        bit  stalled;
        logic [CL_W-1:0] c;
        n       = active_lane_count();
        best    = 0;
        found   = 1'b0;
        stalled = 1'b0;
        has     = 1'b0;
        res     = '0;
        for (i = 0; i < n; i++)
        begin
            if (!pend_valid[i] && !closed[i])
                stalled = 1'b1;
            else if (pend_valid[i] && (!found || pend_stamp[i] < pend_stamp[best]))
            begin
                best  = i;
                found = 1'b1;
            end
        end
        if (!stalled && found)
        begin
            pend_valid[best] = 1'b0;
            c = pend_cluster[best];
            if (tally[best][c] != '1)
                tally[best][c] = tally[best][c] + 1'b1;
            has         = 1'b1;
            res.kind    = KIND_RECORD;
            res.lane    = LANE_W'(best);
            res.cluster = c;
            res.stamp   = pend_stamp[best];
            res.count   = tally[best][c];
        end
    endtask

    task automatic predict_request(input logic [1:0] c, input logic [LANE_W-1:0] l,
                                   input logic [TIME_BITS-1:0] t,
                                   input logic [CL_W-1:0] cl,
                                   output bit has, output merge_result_t res);
        int n;
        n   = active_lane_count();
        has = 1'b0;
        res = '0;
        case (c)
            CMD_PUSH:
            begin
                if (int'(l) >= n || int'(cl) >= MAX_CLUSTERS || pend_valid[l] || closed[l])
                begin
                    has = 1'b1;
                    res = error_reply(l, cl);
                end
                else
                begin
                    pend_stamp[l]   = t;
                    pend_cluster[l] = cl;
                    pend_valid[l]   = 1'b1;
                    merge_attempt(has, res);
                end
            end
            CMD_END:
            begin
                if (int'(l) >= n || pend_valid[l])
                begin
                    has = 1'b1;
                    res = error_reply(l, cl);
                end
                else
                begin
                    closed[l] = 1'b1;
                    merge_attempt(has, res);
                end
            end
            CMD_READ:
            begin
                has = 1'b1;
                if (int'(l) >= MAX_LANES || int'(cl) >= MAX_CLUSTERS)
                    res = error_reply(l, cl);
                else
                begin
                    res.kind    = KIND_COUNT;
                    res.lane    = l;
                    res.cluster = cl;
                    res.count   = tally[l][cl];
                end
            end
            default:
                ;
        endcase
    endtask

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(input logic [1:0] c, input logic [LANE_W-1:0] l,
                                input logic [TIME_BITS-1:0] t,
                                input logic [CL_W-1:0] cl,
                                output bit has, output merge_result_t res);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        cmd         <= c;
        lane        <= l;
        sample_time <= t;
        cluster     <= cl;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_request(c, l, t, cl, has, res);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_lanes(input int value);
        drain_results();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= LIU_W'(value);
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        lanes_cfg = LIU_W'(value);
    endtask

    function automatic logic [TIME_BITS-1:0] random_stamp();
        case ($urandom_range(3))
            0:       return TIME_BITS'($urandom_range(15));
            1:       return {{(TIME_BITS-4){1'b1}}, 4'($urandom_range(15))};
            default: return TIME_BITS'($urandom);
        endcase
    endfunction

    task automatic random_request(input bit closing);
        logic [1:0]           c;
        logic [LANE_W-1:0]    l;
        logic [TIME_BITS-1:0] t;
        logic [CL_W-1:0]      cl;
        int                   n;
        int                   i;
        int                   roll;
        int                   open_lanes[$];
        int                   held_lanes[$];
        bit                   has;
        merge_result_t        res;
        n = active_lane_count();
        for (i = 0; i < n; i++)
        begin
            if (pend_valid[i])
                held_lanes.push_back(i);
            else if (!closed[i])
                open_lanes.push_back(i);
        end
        roll = $urandom_range(99);
        c    = CMD_READ;
        l    = LANE_W'($urandom);
        t    = random_stamp();
        cl   = ($urandom_range(1) != 0) ? CL_W'($urandom_range(3)) : CL_W'($urandom);
        if (closing && roll < 4 && open_lanes.size() != 0)
        begin
            c = CMD_END;
            l = LANE_W'(open_lanes[$urandom_range(open_lanes.size() - 1)]);
        end
        else if (roll < 80 && open_lanes.size() != 0)
        begin
            // fill a lane that blocks the merge
            c = CMD_PUSH;
            l = LANE_W'(open_lanes[$urandom_range(open_lanes.size() - 1)]);
        end
        else if (roll < 88)
            c = CMD_READ;
        else if (roll < 95)
            c = CMD_PUSH;
        else if (roll < 98)
        begin
            // only ends that are refused, so no lane closes by accident
            c = CMD_END;
            if (held_lanes.size() != 0)
                l = LANE_W'(held_lanes[$urandom_range(held_lanes.size() - 1)]);
            else if (n < MAX_LANES)
                l = LANE_W'($urandom_range(MAX_LANES - 1, n));
            else
                c = CMD_READ;
        end
        else
            c = CMD_SPARE;
        send_request(c, l, t, cl, has, res);
        if (has)
            expected_q.push_back(res);
    endtask

    function automatic void add_row(input logic [1:0] c, input int l, input logic [31:0] t,
                                    input int cl, input bit typed, input bit typed_has,
                                    input logic [1:0] k, input int l_o, input int cl_o);
        directed_row_t row;
        row                   = '0;
        row.cmd               = c;
        row.lane              = LANE_W'(l);
        row.stamp             = TIME_BITS'(t);
        row.cluster           = CL_W'(cl);
        row.typed             = typed;
        row.typed_has         = typed_has;
        row.typed_res.kind    = k;
        row.typed_res.lane    = LANE_W'(l_o);
        row.typed_res.cluster = CL_W'(cl_o);
        directed_rows.push_back(row);
    endfunction

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        merge_result_t got;
        merge_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{kind, lane_out, cluster_out, time_out, count_out};
            if (expected_q.size() == 0)
                flag_mismatch($sformatf("unexpected result %p", got));
            else
            begin
                want = expected_q.pop_front();
                if (got.kind !== want.kind || got.lane !== want.lane ||
                    got.cluster !== want.cluster || got.stamp !== want.stamp ||
                    got.count !== want.count)
                    flag_mismatch($sformatf("got %p want %p", got, want));
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timestamp_kway_merge_counter_top: mismatch");
        $finish;
    end

    initial
    begin
        int            p;
        int            k;
        int            i;
        int            j;
        bit            has;
        merge_result_t res;
        directed_row_t row;

        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        cmd            = CMD_PUSH;
        lane           = '0;
        sample_time    = '0;
        cluster        = '0;
        out_ready      = 1'b0;
        idle_pct       = 0;
        stall_pct      = 0;
        mismatch_count = 0;
        lanes_cfg      = LIU_W'(LIU_RESET);
        for (i = 0; i < MAX_LANES; i++)
        begin
            pend_valid[i]   = 1'b0;
            closed[i]       = 1'b0;
            pend_stamp[i]   = '0;
            pend_cluster[i] = '0;
            for (j = 0; j < MAX_CLUSTERS; j++)
                tally[i][j] = '0;
        end

        // counters cleared, heads empty, all eight lanes in use
        add_row(CMD_READ,  0, 32'h0,        0,  1, 1, KIND_COUNT, 0, 0);
        add_row(CMD_READ,  7, 32'hFFFFFFFF, 63, 1, 1, KIND_COUNT, 7, 63);
        add_row(CMD_SPARE, 5, 32'hFFFFFFFF, 63, 1, 0, KIND_RECORD, 0, 0);
        add_row(CMD_PUSH,  0, 32'hFFFFFFFF, 63, 1, 0, KIND_RECORD, 0, 0);
        add_row(CMD_PUSH,  0, 32'd5,        1,  1, 1, KIND_ERROR, 0, 1);
        add_row(CMD_END,   0, 32'h0,        12, 1, 1, KIND_ERROR, 0, 12);
        add_row(CMD_END,   7, 32'h0,        0,  1, 0, KIND_RECORD, 0, 0);
        add_row(CMD_END,   7, 32'h0,        0,  1, 0, KIND_RECORD, 0, 0);
        add_row(CMD_PUSH,  7, 32'd1,        2,  1, 1, KIND_ERROR, 7, 2);
        add_row(CMD_PUSH,  1, 32'h0,        0,  1, 0, KIND_RECORD, 0, 0);
        add_row(CMD_PUSH,  2, 32'd100,      5,  1, 0, KIND_RECORD, 0, 0);
        add_row(CMD_PUSH,  3, 32'd100,      6,  1, 0, KIND_RECORD, 0, 0);
        add_row(CMD_PUSH,  4, 32'h0,        7,  1, 0, KIND_RECORD, 0, 0);
        add_row(CMD_PUSH,  5, 32'h80000000, 40, 1, 0, KIND_RECORD, 0, 0);
        // last open lane filled: merge starts, ties go to the lower lane
        add_row(CMD_PUSH,  6, 32'h7FFFFFFF, 63, 0, 0, KIND_RECORD, 0, 0);
        add_row(CMD_PUSH,  1, 32'h0,        0,  0, 0, KIND_RECORD, 0, 0);
        add_row(CMD_PUSH,  1, 32'd200,      0,  0, 0, KIND_RECORD, 0, 0);
        add_row(CMD_READ,  1, 32'h0,        0,  0, 0, KIND_RECORD, 0, 0);
        add_row(CMD_PUSH,  4, 32'd100,      7,  0, 0, KIND_RECORD, 0, 0);
        add_row(CMD_PUSH,  2, 32'hFFFFFFFF, 5,  0, 0, KIND_RECORD, 0, 0);
        add_row(CMD_PUSH,  3, 32'hFFFFFFFF, 0,  0, 0, KIND_RECORD, 0, 0);
        add_row(CMD_PUSH,  4, 32'hFFFFFFFF, 63, 0, 0, KIND_RECORD, 0, 0);
        add_row(CMD_READ,  6, 32'h0,        63, 0, 0, KIND_RECORD, 0, 0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < directed_rows.size(); k++)
        begin
            row = directed_rows[k];
            send_request(row.cmd, row.lane, row.stamp, row.cluster, has, res);
            if (row.typed)
            begin
                if (row.typed_has)
                    expected_q.push_back(row.typed_res);
            end
            else if (has)
                expected_q.push_back(res);
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // hold the sender until every result is back, then reconfigure
            write_lanes(phase_lanes[p]);
            idle_pct  = phase_idle[p];
            stall_pct = phase_stall[p];
            for (k = 0; k < phase_items[p]; k++)
                random_request(p == NUM_PHASES - 1);
        end

        drain_results();
        if (mismatch_count == 0)
            $display("timestamp_kway_merge_counter_top: match");
        else
            $display("timestamp_kway_merge_counter_top: mismatch");
        $finish;
    end

endmodule
